[sv/depth_zone_and_bin_tracker_unit_macros.svh]
// Assertion macros for the depth zone and bin tracker port-level checker.
`ifndef DEPTH_ZONE_AND_BIN_TRACKER_UNIT_MACROS_SVH
`define DEPTH_ZONE_AND_BIN_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define DZBT_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define DZBT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

[sv/dzbt_pkg.sv]
// Types, codes and the bin band lookup for the depth zone and bin tracker.
package dzbt_pkg;

    localparam int DEPTH_W  = 20;
    localparam int THRESH_W = 19;
    localparam int BIN_W    = 11;
    localparam int CROSS_W  = 2;

    // Item kinds carried in the input side-band.
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Crossing codes.
    localparam logic [CROSS_W-1:0] CROSS_NONE    = 2'd0;
    localparam logic [CROSS_W-1:0] CROSS_SHALLOW = 2'd1;
    localparam logic [CROSS_W-1:0] CROSS_DEEP    = 2'd2;

    // Zone codes.
    localparam logic ZONE_HIGH = 1'b0;
    localparam logic ZONE_LOW  = 1'b1;

    // Register word index.
    localparam logic REG_CROSSING_DEPTH = 1'b0;

    localparam logic [THRESH_W-1:0] CROSSING_DEPTH_RST = 19'd10000;

    // Band edges and bin sizes, centimetres.
    localparam logic signed [DEPTH_W-1:0] SURFACE_CM  = 20'sd200;
    localparam logic signed [DEPTH_W-1:0] BAND_DEEP   = 20'sd100000;
    localparam logic signed [DEPTH_W-1:0] BAND_MID    = 20'sd50000;
    localparam logic signed [DEPTH_W-1:0] BAND_SHELF  = 20'sd10000;

    localparam logic [BIN_W-1:0] BIN_NONE  = 11'd0;
    localparam logic [BIN_W-1:0] BIN_SMALL = 11'd500;
    localparam logic [BIN_W-1:0] BIN_MED   = 11'd1000;
    localparam logic [BIN_W-1:0] BIN_WIDE  = 11'd2000;

    typedef struct packed {
        logic                       op;
        logic signed [DEPTH_W-1:0]  depth;
        logic signed [DEPTH_W-1:0]  prior_depth;
    } t_item;

    typedef struct packed {
        logic                       zone;
        logic signed [DEPTH_W-1:0]  bin_start;
        logic [BIN_W-1:0]           bin_width;
    } t_state;

    typedef struct packed {
        logic [BIN_W-1:0]   bin_size;
        logic               block_end;
        logic               zone;
        logic [CROSS_W-1:0] crossing;
    } t_result;

    // Bin size picked for a bin anchored at the given depth.
    function automatic logic [BIN_W-1:0] band_width(input logic signed [DEPTH_W-1:0] start);
        logic [BIN_W-1:0] w;
        if (start > BAND_DEEP) begin
            w = BIN_WIDE;
        end else if (start > BAND_MID) begin
            w = BIN_WIDE;
        end else if (start > BAND_SHELF) begin
            w = BIN_MED;
        end else if (start > SURFACE_CM) begin
            w = BIN_SMALL;
        end else begin
            w = BIN_NONE;
        end
        return w;
    endfunction

endpackage

[sv/dzbt_apb_regs.sv]
// Configuration register block holding the crossing depth threshold.
module dzbt_apb_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [dzbt_pkg::THRESH_W-1:0]   o_crossing_depth
);
    import dzbt_pkg::*;

    logic [THRESH_W-1:0] r_crossing_depth;
    logic [THRESH_W-1:0] n_crossing_depth;
    logic                w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_crossing_depth = r_crossing_depth;
        if (w_wr && (paddr[2] == REG_CROSSING_DEPTH)) begin
            n_crossing_depth = pwdata[THRESH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crossing_depth <= CROSSING_DEPTH_RST;
        end else begin
            r_crossing_depth <= n_crossing_depth;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CROSSING_DEPTH: prdata = {{(32-THRESH_W){1'b0}}, r_crossing_depth};
            default:            prdata = 32'd0;
        endcase
    end

    assign o_crossing_depth = r_crossing_depth;

endmodule

[sv/dzbt_step.sv]
// Combinational update of zone and depth bin for one item.
module dzbt_step (
    input  dzbt_pkg::t_item                 i_item,
    input  dzbt_pkg::t_state                i_state,
    input  logic [dzbt_pkg::THRESH_W-1:0]   i_crossing_depth,
    output dzbt_pkg::t_state                o_state,
    output dzbt_pkg::t_result               o_result
);
    import dzbt_pkg::*;

    logic signed [DEPTH_W:0] w_d;
    logic signed [DEPTH_W:0] w_p;
    logic signed [DEPTH_W:0] w_t;
    logic signed [DEPTH_W:0] w_start;
    logic signed [DEPTH_W:0] w_lo;
    logic signed [DEPTH_W:0] w_hi;
    logic                    w_close;
    logic [CROSS_W-1:0]      w_cross;
    logic                    w_zone;

    // One extra bit keeps the bin edges exact for any start value.
    assign w_d     = {i_item.depth[DEPTH_W-1], i_item.depth};
    assign w_p     = {i_item.prior_depth[DEPTH_W-1], i_item.prior_depth};
    assign w_t     = {2'b00, i_crossing_depth};
    assign w_start = {i_state.bin_start[DEPTH_W-1], i_state.bin_start};
    assign w_lo    = w_start - $signed({{(DEPTH_W+1-BIN_W){1'b0}}, i_state.bin_width});
    assign w_hi    = w_start + $signed({{(DEPTH_W+1-BIN_W){1'b0}}, i_state.bin_width});

    always_comb begin
        w_cross = CROSS_NONE;
        w_zone  = i_state.zone;
        w_close = 1'b0;
        if (i_item.op == OP_SAMPLE) begin
            if ((w_p > w_t) && (w_d <= w_t)) begin
                w_cross = CROSS_SHALLOW;
                w_zone  = ZONE_HIGH;
            end else if ((w_p < w_t) && (w_d >= w_t)) begin
                w_cross = CROSS_DEEP;
                w_zone  = ZONE_LOW;
            end
            if (w_d < w_start) begin
                w_close = (w_d < w_lo) || (i_item.depth < SURFACE_CM);
            end else if (w_d > w_start) begin
                w_close = (w_d > w_hi);
            end
        end
    end

    always_comb begin
        o_state.zone = w_zone;
        if ((i_item.op == OP_RESTART) || w_close) begin
            o_state.bin_start = i_item.depth;
            o_state.bin_width = band_width(i_item.depth);
        end else begin
            o_state.bin_start = i_state.bin_start;
            o_state.bin_width = i_state.bin_width;
        end
    end

    assign o_result.crossing  = w_cross;
    assign o_result.zone      = w_zone;
    assign o_result.block_end = w_close;
    assign o_result.bin_size  = o_state.bin_width;

endmodule

[sv/depth_zone_and_bin_tracker_unit.sv]
// Top level of the depth zone and bin tracker: stream ports, pipeline and state.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-------------------------------------
//  s_        | in        | s_tvalid / s_tready    | s_tdata depth, previous depth; s_tuser kind
//  m_        | out       | m_tvalid / m_tready    | m_tdata crossing, zone, block end, bin size
//  apb       | in        | psel, penable, pready  | crossing depth threshold at address 0
//
// Every item gives exactly one result, passing through the input register and then
// the output register; one item is accepted per cycle while the output side is not
// stalled, a rate set by the feedback of zone and bin state around the update logic.
// Synchronous active-low reset empties both stages and restores the threshold to
// 10000 cm, the zone to high and the bin to start 0, size 0. A stalled result
// holds in the output register; s_tready drops once the input register is full too.
module depth_zone_and_bin_tracker_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // [19:0] depth, [39:20] previous_depth
    input  logic         s_tuser,   // [0] operation
    // Output stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // [1:0] crossing, [2] zone, [3] block_end,
                                    // [14:4] bin_size, [15] zero
    // Configuration.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import dzbt_pkg::*;

    logic [THRESH_W-1:0] w_crossing_depth;

    // Input stage.
    logic    r_s1_valid;
    logic    n_s1_valid;
    t_item   r_s1_item;

    // Tracker state, updated as an item leaves the input stage.
    t_state  r_state;
    t_state  w_next_state;
    t_result w_result;

    // Output stage.
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;

    logic    w_out_free;
    logic    w_s1_move;
    logic    w_in_take;

    dzbt_apb_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_crossing_depth (w_crossing_depth)
    );

    dzbt_step u_step (
        .i_item           (r_s1_item),
        .i_state          (r_state),
        .i_crossing_depth (w_crossing_depth),
        .o_state          (w_next_state),
        .o_result         (w_result)
    );

    // The output register frees up when it is empty or its result is taken now.
    assign w_out_free = !r_out_valid || m_tready;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign s_tready   = !r_s1_valid || w_out_free;
    assign w_in_take  = s_tvalid && s_tready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_in_take) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_move) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_s1_move) begin
            n_out_valid = 1'b1;
        end else if (m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_state.zone      <= ZONE_HIGH;
            r_state.bin_start <= '0;
            r_state.bin_width <= BIN_NONE;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (w_s1_move) begin
                r_state <= w_next_state;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_item.op          <= s_tuser;
            r_s1_item.depth       <= s_tdata[DEPTH_W-1:0];
            r_s1_item.prior_depth <= s_tdata[2*DEPTH_W-1:DEPTH_W];
        end
        if (w_s1_move) begin
            r_out <= w_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {1'b0, r_out};

endmodule

[sv/dzbt_checker.sv]
// Port-level checker for the depth zone and bin tracker, with its bind.
`include "depth_zone_and_bin_tracker_unit_macros.svh"

module dzbt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [15:0]  m_tdata,
    input logic         pready
);
    import dzbt_pkg::*;

    logic [CROSS_W-1:0] w_cross;
    logic               w_zone;
    logic [BIN_W-1:0]   w_size;

    assign w_cross = m_tdata[1:0];
    assign w_zone  = m_tdata[2];
    assign w_size  = m_tdata[14:4];

    `DZBT_ASSERT_NOW(a_pready_high, i_clk, i_rst_n, 1'b1, pready)

    `DZBT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    `DZBT_ASSERT_NOW(a_cross_zone, i_clk, i_rst_n, m_tvalid && (w_cross != CROSS_NONE), ((w_cross == CROSS_SHALLOW) && (w_zone == ZONE_HIGH)) || ((w_cross == CROSS_DEEP) && (w_zone == ZONE_LOW)))

    `DZBT_ASSERT_NOW(a_bin_band, i_clk, i_rst_n, m_tvalid, (w_size == BIN_NONE) || (w_size == BIN_SMALL) || (w_size == BIN_MED) || (w_size == BIN_WIDE))

endmodule

bind depth_zone_and_bin_tracker_unit dzbt_checker u_dzbt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

[dv/dzbt_result_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts every result of the depth zone and bin tracker and compares it.
module dzbt_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // [19:0] depth, [39:20] previous_depth
    input  logic        i_s_tuser,   // [0] operation
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [1:0] crossing, [2] zone, [3] block_end,
                                     // [14:4] bin_size, [15] zero
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_failures,
    output int          o_outstanding
);
    import dzbt_pkg::*;

    localparam logic [2:0] THRESH_ADDR = 3'(4 * REG_CROSSING_DEPTH);

    logic [THRESH_W-1:0]       threshold;
    logic                      zone_now;
    logic signed [DEPTH_W-1:0] anchor_depth;
    logic [BIN_W-1:0]          span;
    t_result                   pending_results[$];
    int                        fail_count = 0;

    assign o_failures = fail_count;

    // Bin size for a bin anchored at the given depth; the two deepest bands share a size.
    function automatic logic [BIN_W-1:0] span_at(int depth);
        if (depth > BAND_MID) begin
            return BIN_WIDE;
        end else if (depth > BAND_SHELF) begin
            return BIN_MED;
        end else if (depth > SURFACE_CM) begin
            return BIN_SMALL;
        end
        return BIN_NONE;
    endfunction

    // Advances the zone and bin state by one item and returns the result it must produce.
    function automatic t_result track_item(logic op, int depth, int prior_depth);
        int      thr;
        int      start;
        logic    closes;
        t_result res;
        thr = int'(threshold);
        start = int'(anchor_depth);
        closes = 1'b0;
        res.crossing = CROSS_NONE;
        if (op == OP_SAMPLE) begin
            if (prior_depth > thr && depth <= thr) begin
                zone_now = ZONE_HIGH;
                res.crossing = CROSS_SHALLOW;
            end else if (prior_depth < thr && depth >= thr) begin
                zone_now = ZONE_LOW;
                res.crossing = CROSS_DEEP;
            end
            if (depth < start) begin
                closes = (depth < start - int'(span)) || (depth < SURFACE_CM);
            end else if (depth > start) begin
                closes = depth > start + int'(span);
            end
        end
        if (closes || op == OP_RESTART) begin
            anchor_depth = DEPTH_W'(depth);
            span = span_at(depth);
        end
        res.zone = zone_now;
        res.block_end = closes;
        res.bin_size = span;
        return res;
    endfunction

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            threshold = CROSSING_DEPTH_RST;
            zone_now = ZONE_HIGH;
            anchor_depth = '0;
            span = BIN_NONE;
            pending_results.delete();
            o_outstanding <= 0;
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == THRESH_ADDR) begin
                if (i_pwrite) begin
                    threshold = i_pwdata[THRESH_W-1:0];
                end else begin
                    compare_field("crossing_depth", 16'(threshold), i_prdata[15:0]);
                    compare_field("crossing_depth upper bits", 16'(threshold >> 16),
                                  i_prdata[31:16]);
                end
            end
            // Push before pop so that a result leaving as its item is taken is still judged fairly.
            if (i_s_tvalid && i_s_tready) begin
                pending_results.push_back(track_item(i_s_tuser,
                                                     int'($signed(i_s_tdata[19:0])),
                                                     int'($signed(i_s_tdata[39:20]))));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[$bits(t_result)-1:0];
                if (pending_results.size() == 0) begin
                    $error("result with no item waiting: tdata %h", i_m_tdata);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("crossing", 16'(want.crossing), 16'(got.crossing));
                    compare_field("zone", 16'(want.zone), 16'(got.zone));
                    compare_field("block_end", 16'(want.block_end), 16'(got.block_end));
                    compare_field("bin_size", 16'(want.bin_size), 16'(got.bin_size));
                end
            end
            o_outstanding <= pending_results.size();
        end
    end

endmodule

[dv/tb_depth_zone_and_bin_tracker_unit.sv]
`timescale 1ns / 1ps
// Testbench top for the depth zone and bin tracker: stimulus, flow control and verdict.
module tb_depth_zone_and_bin_tracker_unit;
    import dzbt_pkg::*;

    // Results come out of the output register; a handful of quiet cycles is normal,
    // a long stretch with no handshake at all means the block has hung.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int DEPTH_MIN       = -100000;
    localparam int DEPTH_MAX       = 300000;
    localparam int THRESH_MAX      = 300000;
    localparam logic [2:0] THRESH_ADDR = 3'(4 * REG_CROSSING_DEPTH);

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // [19:0] depth, [39:20] previous_depth
    logic        s_tuser;    // [0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [1:0] crossing, [2] zone, [3] block_end, [14:4] bin_size
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int   fail_count;
    int   pending_count;
    int   quiet_cycles = 0;
    // When set, both the sender and the receiver run without any idle cycles.
    logic no_idle = 1'b0;

    always #4 i_clk = ~i_clk;

    depth_zone_and_bin_tracker_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dzbt_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_failures    (fail_count),
        .o_outstanding (pending_count)
    );

    // Watchdog: any handshake on either stream or any register access counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("depth_zone_and_bin_tracker_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result receiver. Before each result it holds tready low for a random number of
    // cycles, so that back-pressure lands on every stage of the two-deep pipeline.
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(4);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    function automatic int clamp_depth(int depth);
        if (depth < DEPTH_MIN) return DEPTH_MIN;
        if (depth > DEPTH_MAX) return DEPTH_MAX;
        return depth;
    endfunction

    // A depth anywhere in range, within three of the threshold, or within three of a band
    // edge, zero or a range end, so that the equal and off-by-one comparisons are hit often.
    function automatic int pick_depth(int thr);
        int marks[7];
        int depth;
        marks = '{DEPTH_MIN, 0, int'(SURFACE_CM), int'(BAND_SHELF), int'(BAND_MID),
                  int'(BAND_DEEP), DEPTH_MAX};
        case ($urandom_range(2))
            0: begin
                depth = int'($urandom_range(DEPTH_MAX - DEPTH_MIN)) + DEPTH_MIN;
            end
            1: begin
                depth = thr + int'($urandom_range(6)) - 3;
            end
            default: begin
                depth = marks[$urandom_range(6)] + int'($urandom_range(6)) - 3;
            end
        endcase
        return clamp_depth(depth);
    endfunction

    // Offers one item after a random gap and returns at the edge where it is taken.
    task automatic push_item(input logic op, input int depth, input int prior_depth);
        int gap;
        logic [DEPTH_W-1:0] depth_bits;
        logic [DEPTH_W-1:0] prev_bits;
        gap = no_idle ? 0 : $urandom_range(4);
        depth_bits = DEPTH_W'(depth);
        prev_bits = DEPTH_W'(prior_depth);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {prev_bits, depth_bits};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Stops the input stream and waits until every result has been collected.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // A setup phase and an access phase, then the bus is released before returning.
    task automatic apb_access(input logic write, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= THRESH_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // The threshold only changes with the pipeline empty; the read-back is checked too.
    task automatic set_threshold(input int thr);
        drain();
        apb_access(1'b1, 32'(thr));
        apb_access(1'b0, 32'd0);
    endtask

    // Mostly a plausible dive profile: each sample's previous depth is the last depth
    // sent, and it moves by a modest step so bins close and stay open in turn. Mixed in
    // are restarts, samples that stand still, jumps, and samples with unrelated depths.
    task automatic run_profile(input int count, input int thr);
        int cur;
        int depth;
        int n;
        cur = pick_depth(thr);
        for (n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                no_idle = ($urandom_range(2) == 0);
            end
            case ($urandom_range(19))
                0, 1: begin
                    depth = pick_depth(thr);
                    push_item(OP_RESTART, depth,
                              int'($urandom_range(DEPTH_MAX - DEPTH_MIN)) + DEPTH_MIN);
                    cur = depth;
                end
                2, 3, 4: begin
                    push_item(OP_SAMPLE, pick_depth(thr), pick_depth(thr));
                end
                5: begin
                    push_item(OP_SAMPLE, cur, cur);
                end
                6, 7: begin
                    depth = pick_depth(thr);
                    push_item(OP_SAMPLE, depth, cur);
                    cur = depth;
                end
                default: begin
                    depth = clamp_depth(cur + int'($urandom_range(3000)) - 1500);
                    push_item(OP_SAMPLE, depth, cur);
                    cur = depth;
                end
            endcase
        end
    endtask

    initial begin
        int phase;
        int thr;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_SAMPLE;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset threshold of 10000 cm. The bin starts at 0 with no
        // width, so the first sample at 0 leaves it open.
        push_item(OP_SAMPLE, 0, 0);
        // Full-range swings: shallower crossing, then deeper crossing, each closing a bin.
        push_item(OP_SAMPLE, DEPTH_MIN, DEPTH_MAX);
        push_item(OP_SAMPLE, DEPTH_MAX, DEPTH_MIN);
        // Exactly at the lower bin edge the bin stays open; one past it closes.
        push_item(OP_SAMPLE, DEPTH_MAX - 2000, DEPTH_MAX);
        push_item(OP_SAMPLE, DEPTH_MAX - 2001, DEPTH_MAX - 2000);
        // Restarts on each side of every band edge.
        push_item(OP_RESTART, 100001, DEPTH_MIN);
        push_item(OP_RESTART, 100000, DEPTH_MAX);
        push_item(OP_RESTART, 50001, 0);
        push_item(OP_RESTART, 50000, 0);
        push_item(OP_RESTART, 10001, 0);
        push_item(OP_RESTART, 10000, 0);
        push_item(OP_RESTART, 201, 0);
        push_item(OP_RESTART, 200, 0);
        // Landing exactly on the threshold from either side; leaving from it is no crossing.
        push_item(OP_SAMPLE, 10000, 9999);
        push_item(OP_SAMPLE, 10000, 10001);
        // Exactly at the upper bin edge stays open; one past it closes.
        push_item(OP_SAMPLE, 10500, 10000);
        push_item(OP_SAMPLE, 10501, 10500);
        // Moving up inside the bin but shallower than the surface edge closes anyway.
        push_item(OP_RESTART, 300, 0);
        push_item(OP_SAMPLE, 199, 300);
        push_item(OP_SAMPLE, -1, 199);

        // Threshold at its lowest value.
        set_threshold(0);
        push_item(OP_SAMPLE, 0, 1);
        push_item(OP_SAMPLE, 0, -1);
        push_item(OP_SAMPLE, -1, 0);

        // Threshold at the highest value the bench uses.
        set_threshold(THRESH_MAX);
        push_item(OP_SAMPLE, DEPTH_MAX, DEPTH_MAX - 1);
        push_item(OP_SAMPLE, DEPTH_MAX - 1, DEPTH_MAX);

        // Random part: a new threshold for every phase, the extremes among them.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                1:       thr = 0;
                3:       thr = THRESH_MAX;
                default: thr = $urandom_range(THRESH_MAX);
            endcase
            set_threshold(thr);
            run_profile(ITEMS_PER_PHASE, thr);
        end

        no_idle = 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("depth_zone_and_bin_tracker_unit test passed");
        end else begin
            $display("depth_zone_and_bin_tracker_unit test failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/dzbt_pkg.sv
sv/dzbt_apb_regs.sv
sv/dzbt_step.sv
sv/depth_zone_and_bin_tracker_unit.sv
sv/dzbt_checker.sv
dv/dzbt_result_checker.sv
dv/tb_depth_zone_and_bin_tracker_unit.sv
